### design/egbo_pkg.sv
// Shared types, constants and format conversions for the edge gather binary op block.
package egbo_pkg;

  localparam int ROWS     = 64;
  localparam int FEAT_MAX = 64;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int ADDR_W   = $clog2(ROWS * FEAT_MAX);

  // command codes carried in tuser
  localparam logic [1:0] CMD_WR_LEFT  = 2'd0;
  localparam logic [1:0] CMD_WR_RIGHT = 2'd1;
  localparam logic [1:0] CMD_EDGE     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_OP   = 2'd0;
  localparam logic [1:0] CFG_PREC = 2'd1;
  localparam logic [1:0] CFG_FDIM = 2'd2;

  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [15:0] QNAN16 = 16'h7E00;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PRE,
    F_ALIGN,
    F_DIV,
    F_NORM,
    F_DENORM,
    F_ROUND
  } fpu_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_WAIT,
    S_OUT
  } top_state_t;

  // widen half to single; subnormals come out normalized
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] pos;
    logic [3:0] sh;
    logic [9:0] mm;
    logic [7:0] ex;
    s   = h[15];
    e   = h[14:10];
    m   = h[9:0];
    pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) pos = 4'(i);
    end
    sh = 4'd10 - pos;
    mm = m << sh;
    ex = 8'd103 + 8'(pos);
    if (e == 5'h1F) begin
      half_to_single = (m != 10'd0) ? QNAN32 : {s, 8'hFF, 23'd0};
    end else if (e == 5'd0) begin
      half_to_single = (m == 10'd0) ? {s, 31'd0} : {s, ex, mm, 13'd0};
    end else begin
      half_to_single = {s, 8'(e) + 8'd112, m, 13'd0};
    end
  endfunction

  // round single to half, ties away from zero
  function automatic logic [15:0] single_to_half(input logic [31:0] f);
    logic              s;
    logic [7:0]        e;
    logic [23:0]       sig;
    logic signed [9:0] ex;
    logic signed [9:0] sh;
    logic [11:0]       r;
    logic [24:0]       sum;
    logic [24:0]       t;
    s   = f[31];
    e   = f[30:23];
    sig = {1'b1, f[22:0]};
    ex  = $signed({2'b0, e}) - 10'sd127;
    sh  = -ex - 10'sd1;
    r   = 12'((25'(sig) + 25'd4096) >> 13);
    sum = 25'(sig) + (25'd1 << (sh[4:0] - 5'd1));
    t   = sum >> sh[4:0];
    if (e == 8'hFF) begin
      single_to_half = (f[22:0] != 23'd0) ? QNAN16 : {s, 15'h7C00};
    end else if (e == 8'd0) begin
      single_to_half = {s, 15'd0};
    end else if (ex > 10'sd15) begin
      single_to_half = {s, 15'h7C00};
    end else if (ex >= -10'sd14) begin
      if (r >= 12'd2048) begin
        r  = r >> 1;
        ex = ex + 10'sd1;
      end
      if (ex > 10'sd15) single_to_half = {s, 15'h7C00};
      else single_to_half = {s, 5'(ex + 10'sd15), r[9:0]};
    end else if (sh > 10'sd24) begin
      single_to_half = {s, 15'd0};
    end else begin
      single_to_half = {s, t[14:0]};
    end
  endfunction

endpackage

### design/egbo_table.sv
// Feature table memory: one write port, one registered read port.
module egbo_table (
  input  logic                      clk,
  input  logic                      we,
  input  logic [egbo_pkg::ADDR_W-1:0] waddr,
  input  logic [31:0]               wdata,
  input  logic                      re,
  input  logic [egbo_pkg::ADDR_W-1:0] raddr,
  output logic [31:0]               rdata
);

  logic [31:0] mem [egbo_pkg::ROWS * egbo_pkg::FEAT_MAX];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/egbo_fpu.sv
// Iterative single precision add, subtract, multiply and divide unit.
module egbo_fpu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  egbo_pkg::fpu_req_t req,
  output logic               done,
  output logic [31:0]        res
);

  egbo_pkg::fpu_state_t state_r, state_nxt;
  egbo_pkg::op_t        op_r, op_nxt;
  logic                 sgn_r, sgn_nxt, zsgn_r, zsgn_nxt, esub_r, esub_nxt;
  logic [49:0]          acc_r, acc_nxt, accb_r, accb_nxt;
  logic signed [11:0]   xe_r, xe_nxt, ea_r, ea_nxt, eb_r, eb_nxt;
  logic                 sticky_r, sticky_nxt;
  logic [23:0]          siga_r, siga_nxt, sigb_r, sigb_nxt;
  logic [24:0]          rem_r, rem_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic [31:0]          res_r, res_nxt;
  logic                 done_r, done_nxt;

  logic               sa, sb, sbe;
  logic [7:0]         ea_f, eb_f, ea_n, eb_n, dexp;
  logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swap;
  logic [23:0]        siga_u, sigb_u;
  logic signed [11:0] ela, elb;
  logic [47:0]        prod;
  logic [49:0]        sum;
  logic               ge;
  logic [24:0]        diff, rsel;
  logic [23:0]        sig24;
  logic               g, st, up;
  logic [24:0]        sig25;
  logic signed [11:0] ebias, efin;
  logic [22:0]        frac;

  assign sa     = req.a[31];
  assign sb     = req.b[31];
  assign sbe    = sb ^ (req.op == egbo_pkg::OP_SUB);
  assign ea_f   = req.a[30:23];
  assign eb_f   = req.b[30:23];
  assign ea_n   = (ea_f == 8'd0) ? 8'd1 : ea_f;
  assign eb_n   = (eb_f == 8'd0) ? 8'd1 : eb_f;
  assign nan_a  = (ea_f == 8'hFF) && (req.a[22:0] != 23'd0);
  assign nan_b  = (eb_f == 8'hFF) && (req.b[22:0] != 23'd0);
  assign inf_a  = (ea_f == 8'hFF) && (req.a[22:0] == 23'd0);
  assign inf_b  = (eb_f == 8'hFF) && (req.b[22:0] == 23'd0);
  assign zero_a = req.a[30:0] == 31'd0;
  assign zero_b = req.b[30:0] == 31'd0;
  assign siga_u = {ea_f != 8'd0, req.a[22:0]};
  assign sigb_u = {eb_f != 8'd0, req.b[22:0]};
  assign ela    = $signed({4'd0, ea_n}) - 12'sd150;
  assign elb    = $signed({4'd0, eb_n}) - 12'sd150;
  assign swap   = req.b[30:0] > req.a[30:0];
  assign dexp   = swap ? (eb_n - ea_n) : (ea_n - eb_n);

  assign prod  = siga_r * sigb_r;
  assign sum   = esub_r ? (acc_r - accb_r) : (acc_r + accb_r);
  assign ge    = rem_r >= {1'b0, sigb_r};
  assign diff  = rem_r - {1'b0, sigb_r};
  assign rsel  = ge ? diff : rem_r;

  assign sig24 = acc_r[49:26];
  assign g     = acc_r[25];
  assign st    = (acc_r[24:0] != 25'd0) | sticky_r;
  assign up    = g & (st | sig24[0]);
  assign sig25 = {1'b0, sig24} + 25'(up);
  assign ebias = xe_r + 12'sd176;

  always_comb begin
    if (sig25[24]) begin
      efin = ebias + 12'sd1;
      frac = sig25[23:1];
    end else if (sig25[23]) begin
      efin = ebias;
      frac = sig25[22:0];
    end else begin
      efin = 12'sd0;
      frac = sig25[22:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    sgn_nxt    = sgn_r;
    zsgn_nxt   = zsgn_r;
    esub_nxt   = esub_r;
    acc_nxt    = acc_r;
    accb_nxt   = accb_r;
    xe_nxt     = xe_r;
    ea_nxt     = ea_r;
    eb_nxt     = eb_r;
    sticky_nxt = sticky_r;
    siga_nxt   = siga_r;
    sigb_nxt   = sigb_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    done_nxt   = 1'b0;
    unique case (state_r)
      egbo_pkg::F_IDLE: begin
        if (start) begin
          op_nxt     = req.op;
          sticky_nxt = 1'b0;
          siga_nxt   = siga_u;
          sigb_nxt   = sigb_u;
          ea_nxt     = ela;
          eb_nxt     = elb;
          unique case (req.op)
            egbo_pkg::OP_ADD, egbo_pkg::OP_SUB: begin
              if (nan_a || nan_b || (inf_a && inf_b && (sa != sbe))) begin
                res_nxt  = egbo_pkg::QNAN32;
                done_nxt = 1'b1;
              end else if (inf_a) begin
                res_nxt  = {sa, 8'hFF, 23'd0};
                done_nxt = 1'b1;
              end else if (inf_b) begin
                res_nxt  = {sbe, 8'hFF, 23'd0};
                done_nxt = 1'b1;
              end else begin
                sgn_nxt   = swap ? sbe : sa;
                zsgn_nxt  = sa & sbe;
                esub_nxt  = sa ^ sbe;
                acc_nxt   = {1'b0, swap ? sigb_u : siga_u, 25'd0};
                accb_nxt  = {1'b0, swap ? siga_u : sigb_u, 25'd0};
                xe_nxt    = (swap ? elb : ela) - 12'sd25;
                cnt_nxt   = (dexp > 8'd63) ? 6'd63 : dexp[5:0];
                state_nxt = egbo_pkg::F_ALIGN;
              end
            end
            egbo_pkg::OP_MUL: begin
              sgn_nxt = sa ^ sb;
              if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
                res_nxt  = egbo_pkg::QNAN32;
                done_nxt = 1'b1;
              end else if (inf_a || inf_b) begin
                res_nxt  = {sa ^ sb, 8'hFF, 23'd0};
                done_nxt = 1'b1;
              end else begin
                xe_nxt    = ela + elb;
                state_nxt = egbo_pkg::F_PRE;
              end
            end
            egbo_pkg::OP_DIV: begin
              sgn_nxt = sa ^ sb;
              if (nan_a || nan_b || (zero_a && zero_b) || (inf_a && inf_b)) begin
                res_nxt  = egbo_pkg::QNAN32;
                done_nxt = 1'b1;
              end else if (zero_b || inf_a) begin
                res_nxt  = {sa ^ sb, 8'hFF, 23'd0};
                done_nxt = 1'b1;
              end else if (inf_b || zero_a) begin
                res_nxt  = {sa ^ sb, 31'd0};
                done_nxt = 1'b1;
              end else begin
                state_nxt = egbo_pkg::F_PRE;
              end
            end
            default: ;
          endcase
        end
      end
      egbo_pkg::F_PRE: begin
        if (op_r == egbo_pkg::OP_MUL) begin
          acc_nxt   = {2'b00, prod};
          state_nxt = egbo_pkg::F_NORM;
        end else begin
          // bring subnormal significands up to a leading one
          if (!siga_r[23]) begin
            siga_nxt = siga_r << 1;
            ea_nxt   = ea_r - 12'sd1;
          end
          if (!sigb_r[23]) begin
            sigb_nxt = sigb_r << 1;
            eb_nxt   = eb_r - 12'sd1;
          end
          if (siga_r[23] && sigb_r[23]) begin
            rem_nxt   = {1'b0, siga_r};
            acc_nxt   = 50'd0;
            xe_nxt    = ea_r - eb_r - 12'sd49;
            cnt_nxt   = 6'd49;
            state_nxt = egbo_pkg::F_DIV;
          end
        end
      end
      egbo_pkg::F_ALIGN: begin
        if (cnt_r != 6'd0) begin
          // shift the smaller operand, jam lost bits into the lsb
          accb_nxt = (accb_r >> 1) | {49'd0, accb_r[0]};
          cnt_nxt  = cnt_r - 6'd1;
        end else begin
          acc_nxt = sum;
          if (sum == 50'd0) sgn_nxt = zsgn_r;
          state_nxt = egbo_pkg::F_NORM;
        end
      end
      egbo_pkg::F_DIV: begin
        acc_nxt = {acc_r[48:0], ge};
        rem_nxt = {rsel[23:0], 1'b0};
        if (cnt_r == 6'd0) begin
          sticky_nxt = rsel != 25'd0;
          state_nxt  = egbo_pkg::F_NORM;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      egbo_pkg::F_NORM: begin
        if (acc_r == 50'd0) begin
          res_nxt   = {sgn_r, 31'd0};
          done_nxt  = 1'b1;
          state_nxt = egbo_pkg::F_IDLE;
        end else if (!acc_r[49]) begin
          acc_nxt = acc_r << 1;
          xe_nxt  = xe_r - 12'sd1;
        end else if (xe_r < -12'sd175) begin
          state_nxt = egbo_pkg::F_DENORM;
        end else begin
          state_nxt = egbo_pkg::F_ROUND;
        end
      end
      egbo_pkg::F_DENORM: begin
        // shift right until the exponent reaches the subnormal floor
        if (xe_r == -12'sd175) begin
          state_nxt = egbo_pkg::F_ROUND;
        end else if (acc_r == 50'd0) begin
          xe_nxt    = -12'sd175;
          state_nxt = egbo_pkg::F_ROUND;
        end else begin
          sticky_nxt = sticky_r | acc_r[0];
          acc_nxt    = acc_r >> 1;
          xe_nxt     = xe_r + 12'sd1;
        end
      end
      egbo_pkg::F_ROUND: begin
        if (efin >= 12'sd255) res_nxt = {sgn_r, 8'hFF, 23'd0};
        else res_nxt = {sgn_r, efin[7:0], frac};
        done_nxt  = 1'b1;
        state_nxt = egbo_pkg::F_IDLE;
      end
      default: state_nxt = egbo_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= egbo_pkg::F_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    sgn_r    <= sgn_nxt;
    zsgn_r   <= zsgn_nxt;
    esub_r   <= esub_nxt;
    acc_r    <= acc_nxt;
    accb_r   <= accb_nxt;
    xe_r     <= xe_nxt;
    ea_r     <= ea_nxt;
    eb_r     <= eb_nxt;
    sticky_r <= sticky_nxt;
    siga_r   <= siga_nxt;
    sigb_r   <= sigb_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### design/edge_gather_binary_op.sv
// Top level: feature tables, column sequencer and output register.
//
// Input stream (in_*): each word is a table write or an edge, chosen by
// in_tuser. A write stores one 32-bit element into the left or right table
// and finishes in the cycle it is accepted. An edge reads its left and
// right rows column by column and sends one result word per column, with
// out_tlast on the final column of the row.
// Config channel (cfg_*): always ready; write op_select, precision and
// feat_dim only while no edge is in flight.
// Each result passes through the table read and hand-off, then the shared
// arithmetic unit: add/subtract aligns exponents one bit per cycle, then
// normalizes; multiply forms the product, then normalizes; divide produces
// one quotient bit per cycle, then normalizes. Specials skip the iteration.
// An edge repeats this for each of its feat_dim columns; in_tready is low
// for the whole edge.
// Reset clears the sequencer and the registers to add, single precision,
// feat_dim 64; table contents are undefined until written.
// A stalled receiver holds the result word and its column on out_* until
// out_tready, and the next column waits.
module edge_gather_binary_op (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // table_row, column, value, lhs_row, rhs_row
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // result_value, result_column
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int AW = egbo_pkg::ADDR_W;
  localparam int RW = egbo_pkg::ROW_W;
  localparam int CW = egbo_pkg::COL_W;

  egbo_pkg::top_state_t state_r, state_nxt;
  egbo_pkg::op_t        op_r;
  logic                 prec_r;
  logic [6:0]           fdim_r;
  logic [RW-1:0]        lrow_r, lrow_nxt, rrow_r, rrow_nxt;
  logic                 loob_r, loob_nxt, roob_r, roob_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [31:0]          res_r, res_nxt;
  logic [CW-1:0]        rcol_r, rcol_nxt;
  logic                 last_r, last_nxt;

  logic [1:0]    cmd;
  logic [RW-1:0] t_row, l_row, r_row;
  logic [CW-1:0] t_col;
  logic [31:0]   t_val;
  logic          in_acc, wr_ok;
  logic [AW-1:0] waddr, laddr, raddr;
  logic          rd_en;
  logic [31:0]   ldata, rdata, la, rb;
  logic [6:0]    nlim;
  egbo_pkg::fpu_req_t req;
  logic          fpu_start, fpu_done;
  logic [31:0]   fpu_res;

  assign cmd   = in_tuser;
  assign t_row = in_tdata[5:0];
  assign t_col = in_tdata[11:6];
  assign t_val = in_tdata[43:12];
  assign l_row = in_tdata[49:44];
  assign r_row = in_tdata[55:50];

  assign in_tready = state_r == egbo_pkg::S_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign wr_ok = (32'(t_row) < egbo_pkg::ROWS) && (32'(t_col) < egbo_pkg::FEAT_MAX);
  assign waddr = AW'(AW'(t_row) * AW'(egbo_pkg::FEAT_MAX) + AW'(t_col));
  assign laddr = AW'(AW'(lrow_r) * AW'(egbo_pkg::FEAT_MAX) + AW'(col_r));
  assign raddr = AW'(AW'(rrow_r) * AW'(egbo_pkg::FEAT_MAX) + AW'(col_r));
  assign rd_en = state_r == egbo_pkg::S_READ;

  egbo_table u_left (
    .clk   (clk),
    .we    (in_acc && (cmd == egbo_pkg::CMD_WR_LEFT) && wr_ok),
    .waddr (waddr),
    .wdata (t_val),
    .re    (rd_en),
    .raddr (laddr),
    .rdata (ldata)
  );

  egbo_table u_right (
    .clk   (clk),
    .we    (in_acc && (cmd == egbo_pkg::CMD_WR_RIGHT) && wr_ok),
    .waddr (waddr),
    .wdata (t_val),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // rows beyond the table read as zero
  assign la = loob_r ? 32'd0 : ldata;
  assign rb = roob_r ? 32'd0 : rdata;

  assign req.op = op_r;
  assign req.a  = prec_r ? egbo_pkg::half_to_single(la[15:0]) : la;
  assign req.b  = prec_r ? egbo_pkg::half_to_single(rb[15:0]) : rb;
  assign fpu_start = state_r == egbo_pkg::S_START;

  egbo_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fpu_start),
    .req   (req),
    .done  (fpu_done),
    .res   (fpu_res)
  );

  assign nlim = (fdim_r > 7'(egbo_pkg::FEAT_MAX)) ? 7'(egbo_pkg::FEAT_MAX) : fdim_r;

  always_comb begin
    state_nxt = state_r;
    lrow_nxt  = lrow_r;
    rrow_nxt  = rrow_r;
    loob_nxt  = loob_r;
    roob_nxt  = roob_r;
    col_nxt   = col_r;
    res_nxt   = res_r;
    rcol_nxt  = rcol_r;
    last_nxt  = last_r;
    unique case (state_r)
      egbo_pkg::S_IDLE: begin
        if (in_acc && (cmd == egbo_pkg::CMD_EDGE) && (nlim != 7'd0)) begin
          lrow_nxt  = l_row;
          rrow_nxt  = r_row;
          loob_nxt  = 32'(l_row) >= egbo_pkg::ROWS;
          roob_nxt  = 32'(r_row) >= egbo_pkg::ROWS;
          col_nxt   = '0;
          state_nxt = egbo_pkg::S_READ;
        end
      end
      egbo_pkg::S_READ:  state_nxt = egbo_pkg::S_START;
      egbo_pkg::S_START: state_nxt = egbo_pkg::S_WAIT;
      egbo_pkg::S_WAIT: begin
        if (fpu_done) begin
          res_nxt   = prec_r ? {16'd0, egbo_pkg::single_to_half(fpu_res)} : fpu_res;
          rcol_nxt  = col_r;
          last_nxt  = (7'(col_r) + 7'd1) == nlim;
          state_nxt = egbo_pkg::S_OUT;
        end
      end
      egbo_pkg::S_OUT: begin
        if (out_tready) begin
          if (last_r) begin
            state_nxt = egbo_pkg::S_IDLE;
          end else begin
            col_nxt   = col_r + CW'(1);
            state_nxt = egbo_pkg::S_READ;
          end
        end
      end
      default: state_nxt = egbo_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= egbo_pkg::S_IDLE;
      op_r    <= egbo_pkg::OP_ADD;
      prec_r  <= 1'b0;
      fdim_r  <= 7'd64;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          egbo_pkg::CFG_OP:   op_r   <= egbo_pkg::op_t'(cfg_data[1:0]);
          egbo_pkg::CFG_PREC: prec_r <= cfg_data[0];
          egbo_pkg::CFG_FDIM: fdim_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    lrow_r <= lrow_nxt;
    rrow_r <= rrow_nxt;
    loob_r <= loob_nxt;
    roob_r <= roob_nxt;
    col_r  <= col_nxt;
    res_r  <= res_nxt;
    rcol_r <= rcol_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = state_r == egbo_pkg::S_OUT;
  assign out_tdata  = {2'b00, rcol_r, res_r};
  assign out_tlast  = last_r;

endmodule

### design/egbo_checker.sv
// Port-level checks for the edge gather binary op block, bound to the top.
module egbo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [55:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [6:0]  cfg_data
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // input is never taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // a word in never yields a result in the next cycle
  a_in_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result too soon after input word");

  // mid-row result keeps the input closed
  a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready)
    else $error("input reopened before row end");

endmodule

bind edge_gather_binary_op egbo_checker u_egbo_checker (.*);
